// ----- hw/rtl/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC frame checker package
// Shared types, constants and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned CountW     = 17;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] MinFrameBytes = CountW'(13);
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;

  localparam logic [CfgIdxW-1:0] CfgMagicFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMagicSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVersion     = 2'd2;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatShort    = 3'd1,
    StatMagic    = 3'd2,
    StatVersion  = 3'd3,
    StatLength   = 3'd4,
    StatCrc      = 3'd5
  } status_e;

  typedef struct packed {
    logic accept;
    logic last;
    logic feed;
  } crc_ctl_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/cfc_if.sv -----
// ----------------------------------------------------------------------------
// CRC frame checker channels
// Byte input channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface cfc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] sequence_res;
  logic [15:0] payload_len;

  modport source (output valid, status, frame_type, frame_flags, sequence_res,
                  payload_len, input ready);
  modport sink   (input valid, status, frame_type, frame_flags, sequence_res,
                  payload_len, output ready);
endinterface

// ----- hw/rtl/cfc_crc_track.sv -----
// ----------------------------------------------------------------------------
// CRC tracker
// Running CRC over the frame with a two-byte delay that holds back the CRC.
// ----------------------------------------------------------------------------
module cfc_crc_track import cfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctl_t    ctl_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o,
  output logic [15:0] tail_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] tail_q, tail_d;
  logic [15:0] crc_step;

  assign crc_step = ctl_i.feed ? crc16_feed(crc_q, tail_q[15:8]) : crc_q;

  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    if (ctl_i.accept) begin
      if (ctl_i.last) begin
        crc_d  = CrcInit;
        tail_d = '0;
      end else begin
        crc_d  = crc_step;
        tail_d = {tail_q[7:0], data_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      tail_q <= '0;
    end else begin
      crc_q  <= crc_d;
      tail_q <= tail_d;
    end
  end

  assign crc_o  = crc_step;
  assign tail_o = tail_q;

endmodule

// ----- hw/rtl/crc_frame_checker_top.sv -----
// ----------------------------------------------------------------------------
// CRC frame checker
// Checks framed bytes: magic, version, length and CRC-16/CCITT-FALSE.
// Result: valid is registered and rises in the cycle after the last byte of a frame is accepted.
// Throughput: one byte per cycle; input stalls only while a result waits.
// Reset: frame state clears, CRC loads 0xFFFF, registers read zero.
// ----------------------------------------------------------------------------
module crc_frame_checker_top import cfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cfc_in_if.sink              in_i,
  cfc_res_if.source           res_o
);

  logic [7:0]        magic_first_q, magic_second_q, version_q;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        type_q, type_d, type_s;
  logic [7:0]        flags_q, flags_d, flags_s;
  logic [31:0]       seq_q, seq_d, seq_s;
  logic [15:0]       len_q, len_d, len_s;
  logic              magic_bad_q, magic_bad_d, magic_bad_s;
  logic              version_bad_q, version_bad_d, version_bad_s;

  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, status_s;
  logic [7:0]        res_type_q, res_flags_q;
  logic [31:0]       res_seq_q;
  logic [15:0]       res_len_q;

  logic              in_acc, res_acc;
  logic [7:0]        b;
  logic [CountW-1:0] idx, total;
  logic [CountW:0]   expect_total;
  logic [15:0]       crc_s, tail, got;
  crc_ctl_t          crc_ctl;

  assign b       = in_i.frame_byte;
  assign idx     = count_q;
  assign in_i.ready = !res_valid_q || res_o.ready;
  assign in_acc  = in_i.valid && in_i.ready;
  assign res_acc = res_valid_q && res_o.ready;

  assign crc_ctl.accept = in_acc;
  assign crc_ctl.last   = in_i.last_byte;
  assign crc_ctl.feed   = (idx >= CountW'(4));

  cfc_crc_track u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .data_i (b),
    .crc_o  (crc_s),
    .tail_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= '0;
      magic_second_q <= '0;
      version_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMagicFirst:  magic_first_q  <= cfg_data_i;
        CfgMagicSecond: magic_second_q <= cfg_data_i;
        CfgVersion:     version_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    magic_bad_s   = magic_bad_q
                  || ((idx == CountW'(0)) && (b != magic_first_q))
                  || ((idx == CountW'(1)) && (b != magic_second_q));
    version_bad_s = version_bad_q || ((idx == CountW'(2)) && (b != version_q));
    type_s  = (idx == CountW'(3)) ? b : type_q;
    flags_s = (idx == CountW'(4)) ? b : flags_q;
    seq_s   = seq_q;
    len_s   = len_q;
    if (idx == CountW'(5))  seq_s[7:0]   = b;
    if (idx == CountW'(6))  seq_s[15:8]  = b;
    if (idx == CountW'(7))  seq_s[23:16] = b;
    if (idx == CountW'(8))  seq_s[31:24] = b;
    if (idx == CountW'(9))  len_s[7:0]   = b;
    if (idx == CountW'(10)) len_s[15:8]  = b;

    total        = (idx < CountMax) ? idx + CountW'(1) : CountMax;
    expect_total = {1'b0, MinFrameBytes} + (CountW + 1)'(len_s);
    got          = {b, tail[7:0]};

    priority if (total < MinFrameBytes) begin
      status_s = StatShort;
    end else if (magic_bad_s) begin
      status_s = StatMagic;
    end else if (version_bad_s) begin
      status_s = StatVersion;
    end else if ({1'b0, total} != expect_total) begin
      status_s = StatLength;
    end else if (crc_s != got) begin
      status_s = StatCrc;
    end else begin
      status_s = StatOk;
    end
  end

  always_comb begin
    count_d       = count_q;
    type_d        = type_q;
    flags_d       = flags_q;
    seq_d         = seq_q;
    len_d         = len_q;
    magic_bad_d   = magic_bad_q;
    version_bad_d = version_bad_q;
    if (in_acc) begin
      if (in_i.last_byte) begin
        count_d       = '0;
        type_d        = '0;
        flags_d       = '0;
        seq_d         = '0;
        len_d         = '0;
        magic_bad_d   = 1'b0;
        version_bad_d = 1'b0;
      end else begin
        count_d       = (count_q < CountMax) ? count_q + CountW'(1) : count_q;
        type_d        = type_s;
        flags_d       = flags_s;
        seq_d         = seq_s;
        len_d         = len_s;
        magic_bad_d   = magic_bad_s;
        version_bad_d = version_bad_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      type_q        <= '0;
      flags_q       <= '0;
      seq_q         <= '0;
      len_q         <= '0;
      magic_bad_q   <= 1'b0;
      version_bad_q <= 1'b0;
    end else begin
      count_q       <= count_d;
      type_q        <= type_d;
      flags_q       <= flags_d;
      seq_q         <= seq_d;
      len_q         <= len_d;
      magic_bad_q   <= magic_bad_d;
      version_bad_q <= version_bad_d;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (in_acc && in_i.last_byte) begin
      res_valid_d = 1'b1;
    end else if (res_acc) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_byte) begin
      res_status_q <= status_s;
      res_type_q   <= type_s;
      res_flags_q  <= flags_s;
      res_seq_q    <= seq_s;
      res_len_q    <= len_s;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_status_q;
  assign res_o.frame_type     = res_type_q;
  assign res_o.frame_flags    = res_flags_q;
  assign res_o.sequence_res   = res_seq_q;
  assign res_o.payload_len    = res_len_q;

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_byte) |=> (count_q == '0 && !magic_bad_q && !version_bad_q))
    else $error("frame state not cleared after last item");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> res_valid_q)
    else $error("input stalled with empty result register");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(in_acc && in_i.last_byte))
    else $error("result appeared without a last item");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_status_q <= StatCrc))
    else $error("status code out of range");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC frame checker testbench
// Builds streams with chosen header, length, CRC or cut faults, tracks the
// frame state byte by byte to forecast each end-of-frame report, and compares
// every report field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import cfc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    status_e     status;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [15:0] len;
  } frame_report_t;

  typedef enum {
    FrmGood, FrmMagic0, FrmMagic1, FrmVersion, FrmMagicVersion,
    FrmLength, FrmCrc, FrmTruncated, FrmNoise
  } frame_kind_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  cfc_in_if  in_if ();
  cfc_res_if res_if ();

  crc_frame_checker_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .res_o      (res_if)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  logic [7:0]  reg_magic_first;
  logic [7:0]  reg_magic_second;
  logic [7:0]  reg_protocol_version;

  logic [CountW-1:0] fr_count;
  logic [15:0] fr_crc;
  logic [15:0] fr_tail;
  logic [7:0]  fr_type;
  logic [7:0]  fr_flags;
  logic [31:0] fr_seq;
  logic [15:0] fr_len;
  logic        fr_magic_bad;
  logic        fr_version_bad;

  frame_report_t pending_reports[$];
  logic [7:0]    frame_bytes[$];
  int unsigned   bytes_sent = 0;
  int unsigned   fail_count = 0;
  bit            quiet = 1'b0;

  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    fr_count       = '0;
    fr_crc         = CrcInit;
    fr_tail        = '0;
    fr_type        = '0;
    fr_flags       = '0;
    fr_seq         = '0;
    fr_len         = '0;
    fr_magic_bad   = 1'b0;
    fr_version_bad = 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    frame_report_t rep;
    logic [15:0]   crc;
    int unsigned   idx;
    int unsigned   total;
    idx = 32'(fr_count);
    if (idx == 0 && b != reg_magic_first) fr_magic_bad = 1'b1;
    if (idx == 1 && b != reg_magic_second) fr_magic_bad = 1'b1;
    if (idx == 2 && b != reg_protocol_version) fr_version_bad = 1'b1;
    case (idx)
      3: fr_type = b;
      4: fr_flags = b;
      5, 6, 7, 8: fr_seq[8*(idx-5) +: 8] = b;
      9: fr_len[7:0] = b;
      10: fr_len[15:8] = b;
      default: ;
    endcase
    crc = fr_crc;
    if (idx >= 4) crc = crc_ccitt_byte(crc, fr_tail[15:8]);
    if (!last) begin
      fr_crc  = crc;
      fr_tail = {fr_tail[7:0], b};
      if (fr_count != CountMax) fr_count = fr_count + CountW'(1);
      return;
    end
    total = (idx < 32'(CountMax)) ? idx + 1 : 32'(CountMax);
    if (total < 32'(MinFrameBytes)) rep.status = StatShort;
    else if (fr_magic_bad) rep.status = StatMagic;
    else if (fr_version_bad) rep.status = StatVersion;
    else if (total != 32'(MinFrameBytes) + 32'(fr_len)) rep.status = StatLength;
    else if (crc != {b, fr_tail[7:0]}) rep.status = StatCrc;
    else rep.status = StatOk;
    rep.ftype = fr_type;
    rep.flags = fr_flags;
    rep.seq   = fr_seq;
    rep.len   = fr_len;
    pending_reports.push_back(rep);
    clear_frame_state();
  endfunction

  // fill < 0 gives random payload; keep = 0 gives a random cut for truncation
  function automatic void build_frame(frame_kind_e kind, int unsigned pay_len,
                                      logic [7:0] ftype, logic [7:0] flags,
                                      logic [31:0] seq, int fill, int unsigned keep);
    logic [15:0] crc;
    logic [15:0] len_field;
    logic [7:0]  nz;
    int unsigned n;
    frame_bytes = {};
    nz = 8'($urandom_range(1, 255));
    if (kind == FrmNoise) begin
      n = $urandom_range(1, 40);
      repeat (n) frame_bytes.push_back(8'($urandom));
      return;
    end
    len_field = pay_len[15:0];
    if (kind == FrmLength) len_field = len_field + 16'($urandom_range(1, 65535));
    frame_bytes = {reg_magic_first, reg_magic_second, reg_protocol_version, ftype, flags,
                   seq[7:0], seq[15:8], seq[23:16], seq[31:24],
                   len_field[7:0], len_field[15:8]};
    repeat (pay_len) frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    crc = CrcInit;
    for (int i = 2; i < frame_bytes.size(); i++) crc = crc_ccitt_byte(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    case (kind)
      FrmMagic0: frame_bytes[0] ^= nz;
      FrmMagic1: frame_bytes[1] ^= nz;
      FrmVersion: frame_bytes[2] ^= nz;
      FrmMagicVersion: begin
        frame_bytes[0] ^= nz;
        frame_bytes[2] ^= nz;
      end
      FrmCrc: frame_bytes[$urandom_range(2, frame_bytes.size() - 1)] ^= nz;
      FrmTruncated: begin
        n = (keep != 0) ? keep : $urandom_range(1, 12);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.frame_byte <= b;
    in_if.last_byte  <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic wait_reports_drained();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CfgMagicFirst: reg_magic_first = data;
      CfgMagicSecond: reg_magic_second = data;
      CfgVersion: reg_protocol_version = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] ver);
    wait_reports_drained();
    write_reg(CfgMagicFirst, m0);
    write_reg(CfgMagicSecond, m1);
    write_reg(CfgVersion, ver);
    write_reg(CfgUnused, 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : report_monitor
    frame_report_t exp_r;
    static int stall_left = 0;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("report with no frame pending");
        fail_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (res_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, res_if.status);
          fail_count++;
        end
        if (res_if.frame_type !== exp_r.ftype) begin
          $error("frame_type: expected %0h, got %0h", exp_r.ftype, res_if.frame_type);
          fail_count++;
        end
        if (res_if.frame_flags !== exp_r.flags) begin
          $error("frame_flags: expected %0h, got %0h", exp_r.flags, res_if.frame_flags);
          fail_count++;
        end
        if (res_if.sequence_res !== exp_r.seq) begin
          $error("sequence_res: expected %0h, got %0h", exp_r.seq, res_if.sequence_res);
          fail_count++;
        end
        if (res_if.payload_len !== exp_r.len) begin
          $error("payload_len: expected %0h, got %0h", exp_r.len, res_if.payload_len);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      res_if.ready <= (stall_left == 0);
    end
  end

  task automatic test_default_regs();
    build_frame(FrmGood, 0, 8'h00, 8'h00, 32'h0000_0000, 0, 0);
    send_frame();
    build_frame(FrmGood, 3, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 255, 0);
    send_frame();
  endtask

  task automatic test_short_frames();
    build_frame(FrmTruncated, 0, 8'h12, 8'h34, 32'h8765_4321, 0, 1);
    send_frame();
    build_frame(FrmTruncated, 0, 8'h12, 8'h34, 32'h8765_4321, 0, 7);
    send_frame();
    build_frame(FrmTruncated, 4, 8'hC3, 8'h3C, 32'hDEAD_BEEF, -1, 10);
    send_frame();
    build_frame(FrmTruncated, 0, 8'h5A, 8'hA5, 32'h0102_0304, 0, 12);
    send_frame();
  endtask

  task automatic test_check_order();
    set_regs(8'hA5, 8'h5A, 8'h01);
    build_frame(FrmTruncated, 0, 8'h01, 8'h02, 32'h0304_0506, 0, 12);
    frame_bytes[0] ^= 8'h01;
    send_frame();
    build_frame(FrmMagic0, 2, 8'h11, 8'h22, $urandom, -1, 0);
    send_frame();
    build_frame(FrmMagic1, 2, 8'h33, 8'h44, $urandom, -1, 0);
    send_frame();
    build_frame(FrmVersion, 2, 8'h55, 8'h66, $urandom, -1, 0);
    send_frame();
    build_frame(FrmMagicVersion, 2, 8'h77, 8'h88, $urandom, -1, 0);
    send_frame();
    build_frame(FrmLength, 2, 8'h99, 8'hAA, $urandom, -1, 0);
    send_frame();
    build_frame(FrmCrc, 5, 8'hBB, 8'hCC, $urandom, -1, 0);
    send_frame();
    build_frame(FrmGood, 5, 8'hDD, 8'hEE, $urandom, -1, 0);
    send_frame();
  endtask

  task automatic test_reg_extremes();
    set_regs(8'hFF, 8'hFF, 8'hFF);
    build_frame(FrmGood, 4, 8'h80, 8'h01, 32'h8000_0001, 0, 0);
    send_frame();
    build_frame(FrmGood, 4, 8'h7F, 8'hFE, 32'h7FFF_FFFE, 255, 0);
    send_frame();
    set_regs(8'h00, 8'h00, 8'h00);
    build_frame(FrmGood, 1, 8'h00, 8'hFF, 32'h0000_FFFF, -1, 0);
    send_frame();
  endtask

  task automatic test_drain_pause();
    build_frame(FrmGood, 6, 8'($urandom), 8'($urandom), $urandom, -1, 0);
    send_frame();
    wait_reports_drained();
    build_frame(FrmCrc, 6, 8'($urandom), 8'($urandom), $urandom, -1, 0);
    send_frame();
  endtask

  task automatic test_random_frames();
    frame_kind_e kind;
    int unsigned start;
    int unsigned pay;
    int unsigned r;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 62) kind = FrmGood;
      else if (r < 67) kind = FrmMagic0;
      else if (r < 71) kind = FrmMagic1;
      else if (r < 76) kind = FrmVersion;
      else if (r < 78) kind = FrmMagicVersion;
      else if (r < 84) kind = FrmLength;
      else if (r < 91) kind = FrmCrc;
      else if (r < 96) kind = FrmTruncated;
      else kind = FrmNoise;
      pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 16);
      build_frame(kind, pay, 8'($urandom), 8'($urandom), $urandom, -1, 0);
      send_frame();
      if ($urandom_range(0, 24) == 0) set_regs(8'($urandom), 8'($urandom), 8'($urandom));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgMagicFirst;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.frame_byte = '0;
    in_if.last_byte  = 1'b0;
    res_if.ready     = 1'b0;
    reg_magic_first      = '0;
    reg_magic_second     = '0;
    reg_protocol_version = '0;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_regs();
    test_short_frames();
    test_check_order();
    test_reg_extremes();
    test_drain_pause();
    test_random_frames();
    wait_reports_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_if.sv
hw/rtl/cfc_crc_track.sv
hw/rtl/crc_frame_checker_top.sv
tb/tb_top.sv
